@@ hdl/mvp_pkg.sv @@
`timescale 1ns / 1ps

package mvp_pkg;

   // Default geometry and vector precision.
   localparam int MAX_MB_COLS_DEF = 64;
   localparam int MAX_MB_ROWS_DEF = 64;
   localparam int VEC_BITS_DEF    = 16;

   // Picture size registers.
   localparam int        CFG_W         = 7;
   localparam logic [6:0] PIC_DIM_RESET = 7'd64;

   typedef enum logic [0:0] {
      CSR_PIC_WIDTH  = 1'b0,
      CSR_PIC_HEIGHT = 1'b1
   } mvp_csr_type;

   typedef enum logic [1:0] {
      ACT_NEW_PIC = 2'd0,
      ACT_MARK    = 2'd1,
      ACT_DERIVE  = 2'd2,
      ACT_SKIP    = 2'd3
   } mvp_action_type;

   // Neighbor slots: left, top, top-right, top-left, and the two block
   // neighbors that the skip zero test looks at.
   localparam int NB_A     = 0;
   localparam int NB_B     = 1;
   localparam int NB_C     = 2;
   localparam int NB_D     = 3;
   localparam int NB_L     = 4;
   localparam int NB_T     = 5;
   localparam int NB_COUNT = 6;

   typedef struct packed {
      logic       ok;
      logic [8:0] bx;
      logic [7:0] by;
   } mvp_nb_type;

   typedef struct packed {
      mvp_action_type              action;
      logic [9:0]                  org_x;
      logic [9:0]                  org_y;
      logic signed [15:0]          mvd_x;
      logic signed [15:0]          mvd_y;
      logic                        intra;
      logic                        dir_16x8;
      logic                        dir_8x16;
      logic                        skip_edge;
      logic [2:0]                  fill_w;
      logic [2:0]                  fill_h;
      logic [7:0]                  bx0;
      logic [7:0]                  by0;
      logic [9:0]                  lim_x;
      logic [9:0]                  lim_y;
      logic                        mark_ok;
      logic [5:0]                  mb_x;
      logic [5:0]                  mb_y;
      mvp_nb_type [NB_COUNT-1:0]   nb;
   } mvp_entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK,
      ST_READ,
      ST_READ_WAIT,
      ST_PRED,
      ST_SUM,
      ST_FILL,
      ST_DONE
   } mvp_state_type;

endpackage

@@ hdl/mvp_front.sv @@
`timescale 1ns / 1ps

module mvp_front #(
   parameter int MAX_MB_COLS = mvp_pkg::MAX_MB_COLS_DEF,
   parameter int MAX_MB_ROWS = mvp_pkg::MAX_MB_ROWS_DEF
) (
   input  logic [1:0]          req_action,
   input  logic [9:0]          req_org_x,
   input  logic [9:0]          req_org_y,
   input  logic [4:0]          req_part_width,
   input  logic [4:0]          req_part_height,
   input  logic signed [15:0]  req_mvd_x,
   input  logic signed [15:0]  req_mvd_y,
   input  logic                req_mb_is_intra,
   input  logic [6:0]          pic_w,
   input  logic [6:0]          pic_h,
   output mvp_pkg::mvp_entry_type entry
);

   logic [6:0]         eff_w;
   logic [6:0]         eff_h;
   logic [9:0]         lim_x;
   logic [9:0]         lim_y;
   logic [4:0]         w_use;
   logic signed [11:0] ox;
   logic signed [11:0] oy;
   logic               is_skip;

   // Classifies one pixel position against the picture bounds.
   function automatic mvp_pkg::mvp_nb_type nb_at(logic signed [11:0] px,
                                                 logic signed [11:0] py,
                                                 logic [9:0] lx, logic [9:0] ly);
      mvp_pkg::mvp_nb_type n;
      n.bx = px[10:2];
      n.by = py[9:2];
      n.ok = !px[11] && !py[11] && ({1'b0, n.bx} < lx) && ({2'b00, n.by} < ly);
      return n;
   endfunction

   always_comb begin
      eff_w = pic_w;
      if (pic_w == 7'd0) eff_w = 7'd1;
      else if (int'(pic_w) > MAX_MB_COLS) eff_w = 7'(MAX_MB_COLS);
      eff_h = pic_h;
      if (pic_h == 7'd0) eff_h = 7'd1;
      else if (int'(pic_h) > MAX_MB_ROWS) eff_h = 7'(MAX_MB_ROWS);
      lim_x = {1'b0, eff_w, 2'b00};
      lim_y = {1'b0, eff_h, 2'b00};

      is_skip = (mvp_pkg::mvp_action_type'(req_action) == mvp_pkg::ACT_SKIP);
      w_use   = is_skip ? 5'd16 : req_part_width;
      ox      = signed'({2'b00, req_org_x});
      oy      = signed'({2'b00, req_org_y});

      entry.action    = mvp_pkg::mvp_action_type'(req_action);
      entry.org_x     = req_org_x;
      entry.org_y     = req_org_y;
      entry.mvd_x     = req_mvd_x;
      entry.mvd_y     = req_mvd_y;
      entry.intra     = req_mb_is_intra;
      entry.dir_16x8  = !is_skip && (req_part_width == 5'd16) && (req_part_height == 5'd8);
      entry.dir_8x16  = !is_skip && (req_part_width == 5'd8) && (req_part_height == 5'd16);
      entry.skip_edge = (req_org_x == 10'd0) || (req_org_y == 10'd0);
      entry.fill_w    = is_skip ? 3'd4 : req_part_width[4:2];
      entry.fill_h    = is_skip ? 3'd4 : req_part_height[4:2];
      entry.bx0       = req_org_x[9:2];
      entry.by0       = req_org_y[9:2];
      entry.lim_x     = lim_x;
      entry.lim_y     = lim_y;
      entry.mb_x      = req_org_x[9:4];
      entry.mb_y      = req_org_y[9:4];
      entry.mark_ok   = ({1'b0, req_org_x[9:4]} < eff_w) && ({1'b0, req_org_y[9:4]} < eff_h);

      entry.nb[mvp_pkg::NB_A] = nb_at(ox - 12'sd1, oy, lim_x, lim_y);
      entry.nb[mvp_pkg::NB_B] = nb_at(ox, oy - 12'sd1, lim_x, lim_y);
      entry.nb[mvp_pkg::NB_C] = nb_at(ox + signed'({7'd0, w_use}), oy - 12'sd1,
                                      lim_x, lim_y);
      entry.nb[mvp_pkg::NB_D] = nb_at(ox - 12'sd1, oy - 12'sd1, lim_x, lim_y);
      // Whole-block steps: one block left and one block up of the origin block.
      entry.nb[mvp_pkg::NB_L] = nb_at(ox - 12'sd4, oy, lim_x, lim_y);
      entry.nb[mvp_pkg::NB_T] = nb_at(ox, oy - 12'sd4, lim_x, lim_y);
   end

endmodule

@@ hdl/mvp_queue.sv @@
`timescale 1ns / 1ps

module mvp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mvp_pkg::mvp_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   out_valid,
   output mvp_pkg::mvp_entry_type out_data
);

   mvp_pkg::mvp_entry_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_in;
   logic [1:0] count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      out_valid = (count_ff != 2'd0);
      out_data  = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ hdl/mvp_back.sv @@
`timescale 1ns / 1ps

module mvp_back #(
   parameter int MAX_MB_COLS = mvp_pkg::MAX_MB_COLS_DEF,
   parameter int MAX_MB_ROWS = mvp_pkg::MAX_MB_ROWS_DEF,
   parameter int VEC_BITS    = mvp_pkg::VEC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  mvp_pkg::mvp_entry_type q_data,
   output logic                   q_pop,
   output logic                   clearing,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic signed [15:0]     rsp_pred_x,
   output logic signed [15:0]     rsp_pred_y,
   output logic signed [15:0]     rsp_final_x,
   output logic signed [15:0]     rsp_final_y
);

   localparam int BLK_COLS = MAX_MB_COLS * 4;
   localparam int BLK_ROWS = MAX_MB_ROWS * 4;
   localparam int DEPTH    = BLK_COLS * BLK_ROWS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int MB_DEPTH = MAX_MB_COLS * MAX_MB_ROWS;
   localparam int MB_AW    = (MB_DEPTH > 1) ? $clog2(MB_DEPTH) : 1;
   localparam int WORD_W   = 2 * VEC_BITS + 1;
   localparam int SUM_W    = ((VEC_BITS > 16) ? VEC_BITS : 16) + 1;
   localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((64'sd1 <<< (VEC_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] VMIN = -VMAX - SUM_W'(1);

   typedef logic signed [VEC_BITS-1:0] vec_type;

   // Vector store: one word per 4x4 block holding {present, x, y}.
   logic [WORD_W-1:0] vec_mem [DEPTH];
   logic              mb_mem  [MB_DEPTH];

   mvp_pkg::mvp_state_type state_ff, state_in;
   mvp_pkg::mvp_entry_type cur_ff;
   logic                   cur_load;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic                   clr_resp_ff, clr_resp_in;
   logic [2:0]             rd_idx_ff, rd_idx_in;
   logic                   issue;
   logic                   cap_v_ff;
   logic [2:0]             cap_idx_ff;
   logic [2:0]             fi_ff, fi_in, fj_ff, fj_in;

   logic                   vec_we;
   logic [ADDR_W-1:0]      vec_addr;
   logic [WORD_W-1:0]      vec_wdata;
   logic [WORD_W-1:0]      vec_rd_ff;
   logic                   mb_we;
   logic [MB_AW-1:0]       mb_addr;
   logic                   mb_wdata;
   logic                   mb_rd_ff;

   logic [WORD_W-1:0]      nb_word_ff  [mvp_pkg::NB_COUNT];
   logic                   nb_intra_ff [mvp_pkg::NB_COUNT];

   vec_type                pred_x_ff, pred_y_ff, pred_x_in, pred_y_in;
   vec_type                final_x_ff, final_y_ff, final_x_in, final_y_in;
   logic                   load_rsp;
   logic                   rsp_valid_ff;
   logic signed [15:0]     rsp_px_ff, rsp_py_ff, rsp_fx_ff, rsp_fy_ff;

   // Neighbor classification.
   logic    nvalid [mvp_pkg::NB_COUNT];
   logic    navail [mvp_pkg::NB_COUNT];
   vec_type nx     [mvp_pkg::NB_COUNT];
   vec_type ny     [mvp_pkg::NB_COUNT];
   logic    cv;
   vec_type cx, cy;
   logic    skip_zero;
   logic [8:0] fbx, fby;
   logic       fill_in_pic;
   logic signed [SUM_W-1:0] sum_x, sum_y;

   function automatic logic [ADDR_W-1:0] blk_addr(logic [8:0] bx, logic [8:0] by);
      return ADDR_W'(int'(by) * BLK_COLS + int'(bx));
   endfunction

   function automatic logic [MB_AW-1:0] mb_addr_of(logic [8:0] bx, logic [7:0] by);
      return MB_AW'(int'(by[7:2]) * MAX_MB_COLS + int'(bx[8:2]));
   endfunction

   function automatic vec_type mid3(vec_type a, vec_type b, vec_type c);
      vec_type lo_ab, hi_ab, lo_c;
      lo_ab = (a < b) ? a : b;
      hi_ab = (a > b) ? a : b;
      lo_c  = (c < hi_ab) ? c : hi_ab;
      return (lo_ab > lo_c) ? lo_ab : lo_c;
   endfunction

   function automatic vec_type sat(logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = v;
      if (v > VMAX) r = VMAX;
      else if (v < VMIN) r = VMIN;
      return VEC_BITS'(r);
   endfunction

   // Prediction from the captured neighbor words.
   always_comb begin
      for (int k = 0; k < mvp_pkg::NB_COUNT; k++) begin
         nvalid[k] = cur_ff.nb[k].ok && nb_word_ff[k][WORD_W-1];
         navail[k] = cur_ff.nb[k].ok && (nb_word_ff[k][WORD_W-1] || nb_intra_ff[k]);
         nx[k]     = nvalid[k] ? vec_type'(nb_word_ff[k][2*VEC_BITS-1:VEC_BITS]) : '0;
         ny[k]     = nvalid[k] ? vec_type'(nb_word_ff[k][VEC_BITS-1:0]) : '0;
      end
      // The top-left neighbor stands in when the top-right one is unavailable.
      if (navail[mvp_pkg::NB_C]) begin
         cv = nvalid[mvp_pkg::NB_C];
         cx = nx[mvp_pkg::NB_C];
         cy = ny[mvp_pkg::NB_C];
      end else begin
         cv = nvalid[mvp_pkg::NB_D];
         cx = nx[mvp_pkg::NB_D];
         cy = ny[mvp_pkg::NB_D];
      end

      skip_zero = cur_ff.skip_edge
         || (nvalid[mvp_pkg::NB_L] && nx[mvp_pkg::NB_L] == '0 && ny[mvp_pkg::NB_L] == '0)
         || (nvalid[mvp_pkg::NB_T] && nx[mvp_pkg::NB_T] == '0 && ny[mvp_pkg::NB_T] == '0);

      priority if (cur_ff.dir_16x8 && cur_ff.org_y[3] && nvalid[mvp_pkg::NB_A]) begin
         pred_x_in = nx[mvp_pkg::NB_A];
         pred_y_in = ny[mvp_pkg::NB_A];
      end else if (cur_ff.dir_16x8 && !cur_ff.org_y[3] && nvalid[mvp_pkg::NB_B]) begin
         pred_x_in = nx[mvp_pkg::NB_B];
         pred_y_in = ny[mvp_pkg::NB_B];
      end else if (cur_ff.dir_8x16 && cur_ff.org_x[3] && cv) begin
         pred_x_in = cx;
         pred_y_in = cy;
      end else if (cur_ff.dir_8x16 && !cur_ff.org_x[3] && nvalid[mvp_pkg::NB_A]) begin
         pred_x_in = nx[mvp_pkg::NB_A];
         pred_y_in = ny[mvp_pkg::NB_A];
      end else if (!nvalid[mvp_pkg::NB_B] && !cv) begin
         pred_x_in = nx[mvp_pkg::NB_A];
         pred_y_in = ny[mvp_pkg::NB_A];
      end else if (!nvalid[mvp_pkg::NB_A] && nvalid[mvp_pkg::NB_B] && !cv) begin
         pred_x_in = nx[mvp_pkg::NB_B];
         pred_y_in = ny[mvp_pkg::NB_B];
      end else if (!nvalid[mvp_pkg::NB_A] && !nvalid[mvp_pkg::NB_B] && cv) begin
         pred_x_in = cx;
         pred_y_in = cy;
      end else begin
         pred_x_in = mid3(nx[mvp_pkg::NB_A], nx[mvp_pkg::NB_B], cx);
         pred_y_in = mid3(ny[mvp_pkg::NB_A], ny[mvp_pkg::NB_B], cy);
      end
      if (cur_ff.action == mvp_pkg::ACT_SKIP && skip_zero) begin
         pred_x_in = '0;
         pred_y_in = '0;
      end

      sum_x = SUM_W'(pred_x_ff) + SUM_W'(cur_ff.mvd_x);
      sum_y = SUM_W'(pred_y_ff) + SUM_W'(cur_ff.mvd_y);
      if (cur_ff.action == mvp_pkg::ACT_SKIP) begin
         final_x_in = pred_x_ff;
         final_y_in = pred_y_ff;
      end else begin
         final_x_in = sat(sum_x);
         final_y_in = sat(sum_y);
      end

      fbx         = {1'b0, cur_ff.bx0} + {6'd0, fi_ff};
      fby         = {1'b0, cur_ff.by0} + {6'd0, fj_ff};
      fill_in_pic = ({1'b0, fbx} < cur_ff.lim_x) && ({1'b0, fby} < cur_ff.lim_y);
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      clr_resp_in = clr_resp_ff;
      rd_idx_in   = rd_idx_ff;
      fi_in       = fi_ff;
      fj_in       = fj_ff;
      q_pop       = 1'b0;
      cur_load    = 1'b0;
      issue       = 1'b0;
      load_rsp    = 1'b0;
      vec_we      = 1'b0;
      vec_addr    = '0;
      vec_wdata   = '0;
      mb_we       = 1'b0;
      mb_addr     = '0;
      mb_wdata    = 1'b0;
      unique case (state_ff)
         mvp_pkg::ST_CLEAR: begin
            vec_we   = 1'b1;
            vec_addr = clr_ff;
            if ({1'b0, clr_ff} < (ADDR_W + 1)'(MB_DEPTH)) begin
               mb_we   = 1'b1;
               mb_addr = clr_ff[MB_AW-1:0];
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = clr_resp_ff ? mvp_pkg::ST_DONE : mvp_pkg::ST_IDLE;
            end
         end
         mvp_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_load = 1'b1;
               unique case (q_data.action)
                  mvp_pkg::ACT_NEW_PIC: begin
                     state_in    = mvp_pkg::ST_CLEAR;
                     clr_in      = '0;
                     clr_resp_in = 1'b1;
                  end
                  mvp_pkg::ACT_MARK: state_in = mvp_pkg::ST_MARK;
                  default: begin
                     state_in  = mvp_pkg::ST_READ;
                     rd_idx_in = '0;
                  end
               endcase
            end
         end
         mvp_pkg::ST_MARK: begin
            mb_we    = cur_ff.mark_ok;
            mb_addr  = MB_AW'(int'(cur_ff.mb_y) * MAX_MB_COLS + int'(cur_ff.mb_x));
            mb_wdata = cur_ff.intra;
            state_in = mvp_pkg::ST_DONE;
         end
         mvp_pkg::ST_READ: begin
            issue = 1'b1;
            if (cur_ff.nb[rd_idx_ff].ok) begin
               vec_addr = blk_addr(cur_ff.nb[rd_idx_ff].bx, {1'b0, cur_ff.nb[rd_idx_ff].by});
               mb_addr  = mb_addr_of(cur_ff.nb[rd_idx_ff].bx, cur_ff.nb[rd_idx_ff].by);
            end
            rd_idx_in = rd_idx_ff + 3'd1;
            if (rd_idx_ff == 3'(mvp_pkg::NB_COUNT - 1)) state_in = mvp_pkg::ST_READ_WAIT;
         end
         mvp_pkg::ST_READ_WAIT: state_in = mvp_pkg::ST_PRED;
         mvp_pkg::ST_PRED:      state_in = mvp_pkg::ST_SUM;
         mvp_pkg::ST_SUM: begin
            fi_in    = '0;
            fj_in    = '0;
            state_in = (cur_ff.fill_w != 3'd0 && cur_ff.fill_h != 3'd0) ?
                       mvp_pkg::ST_FILL : mvp_pkg::ST_DONE;
         end
         mvp_pkg::ST_FILL: begin
            vec_we    = fill_in_pic;
            vec_addr  = fill_in_pic ? blk_addr(fbx, fby) : '0;
            vec_wdata = {1'b1, final_x_ff, final_y_ff};
            if (fi_ff == cur_ff.fill_w - 3'd1) begin
               fi_in = '0;
               fj_in = fj_ff + 3'd1;
               if (fj_ff == cur_ff.fill_h - 3'd1) state_in = mvp_pkg::ST_DONE;
            end else begin
               fi_in = fi_ff + 3'd1;
            end
         end
         mvp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp    = 1'b1;
               clr_resp_in = 1'b0;
               state_in    = mvp_pkg::ST_IDLE;
            end
         end
         default: state_in = mvp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mvp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         fi_ff        <= '0;
         fj_ff        <= '0;
         cap_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         clr_resp_ff <= clr_resp_in;
         rd_idx_ff   <= rd_idx_in;
         fi_ff       <= fi_in;
         fj_ff       <= fj_in;
         cap_v_ff    <= issue;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Memories: one access per cycle, registered read data.
   always_ff @(posedge clock) begin
      if (vec_we) vec_mem[vec_addr] <= vec_wdata;
      vec_rd_ff <= vec_mem[vec_addr];
   end

   always_ff @(posedge clock) begin
      if (mb_we) mb_mem[mb_addr] <= mb_wdata;
      mb_rd_ff <= mb_mem[mb_addr];
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cap_idx_ff <= rd_idx_ff;
      if (cur_load) cur_ff <= q_data;
      if (cap_v_ff) begin
         nb_word_ff[cap_idx_ff]  <= vec_rd_ff;
         nb_intra_ff[cap_idx_ff] <= mb_rd_ff;
      end
      if (state_ff == mvp_pkg::ST_PRED) begin
         pred_x_ff <= pred_x_in;
         pred_y_ff <= pred_y_in;
      end
      if (state_ff == mvp_pkg::ST_SUM) begin
         final_x_ff <= final_x_in;
         final_y_ff <= final_y_in;
      end
      if (load_rsp) begin
         if (cur_ff.action == mvp_pkg::ACT_DERIVE || cur_ff.action == mvp_pkg::ACT_SKIP) begin
            rsp_px_ff <= 16'(SUM_W'(pred_x_ff));
            rsp_py_ff <= 16'(SUM_W'(pred_y_ff));
            rsp_fx_ff <= 16'(SUM_W'(final_x_ff));
            rsp_fy_ff <= 16'(SUM_W'(final_y_ff));
         end else begin
            rsp_px_ff <= '0;
            rsp_py_ff <= '0;
            rsp_fx_ff <= '0;
            rsp_fy_ff <= '0;
         end
      end
   end

   assign clearing    = (state_ff == mvp_pkg::ST_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pred_x  = rsp_px_ff;
   assign rsp_pred_y  = rsp_py_ff;
   assign rsp_final_x = rsp_fx_ff;
   assign rsp_final_y = rsp_fy_ff;

endmodule

@@ hdl/h264_mv_predictor_core.sv @@
`timescale 1ns / 1ps
// A derive or P_Skip request makes six sequential neighbor reads on the single vector port,
// then visits every 4x4 block that the partition covers (up to 49), writing those inside the
// picture, before its result is returned.
// The back end takes one request at a time; a mark only writes its intra flag.
// Reset and new picture: a clearing sweep runs through all MAX_MB_COLS*MAX_MB_ROWS*16 entries
// of the vector store (65536 by default), one entry per cycle, with requests stalled.
module h264_mv_predictor_core #(
   parameter int MAX_MB_COLS = mvp_pkg::MAX_MB_COLS_DEF,
   parameter int MAX_MB_ROWS = mvp_pkg::MAX_MB_ROWS_DEF,
   parameter int VEC_BITS    = mvp_pkg::VEC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [9:0]         req_org_x,
   input  logic [9:0]         req_org_y,
   input  logic [4:0]         req_part_width,
   input  logic [4:0]         req_part_height,
   input  logic signed [15:0] req_mvd_x,
   input  logic signed [15:0] req_mvd_y,
   input  logic               req_mb_is_intra,
   // Result channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pred_x,
   output logic signed [15:0] rsp_pred_y,
   output logic signed [15:0] rsp_final_x,
   output logic signed [15:0] rsp_final_y,
   // Register write channel.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [6:0]         csr_wdata
);

   // Picture size registers; the user ensures they are written only while the core is idle.
   logic [6:0] pic_w_ff;
   logic [6:0] pic_h_ff;

   mvp_pkg::mvp_entry_type front_entry;
   mvp_pkg::mvp_entry_type q_data;
   logic                   q_full;
   logic                   q_valid;
   logic                   q_pop;
   logic                   clearing;
   logic                   req_accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pic_w_ff <= mvp_pkg::PIC_DIM_RESET;
         pic_h_ff <= mvp_pkg::PIC_DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (mvp_pkg::mvp_csr_type'(csr_index))
            mvp_pkg::CSR_PIC_WIDTH:  pic_w_ff <= csr_wdata;
            mvp_pkg::CSR_PIC_HEIGHT: pic_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A request is taken into the queue unless it is full or the store is being
   // swept clean.
   assign req_stall  = q_full || clearing;
   assign req_accept = req_valid && !req_stall;

   // The front end classifies each request: neighbor positions and their picture
   // bounds, fill extent and the partition shape rules.
   mvp_front #(
      .MAX_MB_COLS (MAX_MB_COLS),
      .MAX_MB_ROWS (MAX_MB_ROWS)
   ) u_front (
      .req_action      (req_action),
      .req_org_x       (req_org_x),
      .req_org_y       (req_org_y),
      .req_part_width  (req_part_width),
      .req_part_height (req_part_height),
      .req_mvd_x       (req_mvd_x),
      .req_mvd_y       (req_mvd_y),
      .req_mb_is_intra (req_mb_is_intra),
      .pic_w           (pic_w_ff),
      .pic_h           (pic_h_ff),
      .entry           (front_entry)
   );

   // Two entries decouple the front end from the sequencer.
   mvp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   // The back end owns the vector store and intra flags, reads the neighbors,
   // forms the prediction, fills the partition and holds the result register.
   mvp_back #(
      .MAX_MB_COLS (MAX_MB_COLS),
      .MAX_MB_ROWS (MAX_MB_ROWS),
      .VEC_BITS    (VEC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .clearing    (clearing),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_pred_x  (rsp_pred_x),
      .rsp_pred_y  (rsp_pred_y),
      .rsp_final_x (rsp_final_x),
      .rsp_final_y (rsp_final_y)
   );

endmodule

@@ dv/h264_mv_predictor_core_tb.sv @@
`timescale 1ns / 1ps

module h264_mv_predictor_core_tb;

   // The run ends here even if the block hangs. The budget covers nine
   // clearing sweeps plus every request under heavy stalls.
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int BLK_COLS    = 256;

   typedef struct {
      mvp_pkg::mvp_action_type act;
      logic [9:0]         ox;
      logic [9:0]         oy;
      logic [4:0]         w;
      logic [4:0]         h;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic               intra;
   } mv_req_t;

   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] fx;
      logic signed [15:0] fy;
   } mv_rsp_t;

   typedef struct {
      int x;
      int y;
      bit avail;
      bit valid;
   } nb_t;

   typedef struct {
      mvp_pkg::mvp_action_type act;
      int ox, oy, w, h, dx, dy;
      bit intra;
      bit typed;
      int epx, epy, efx, efy;
   } dir_row_t;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_action;
   logic [9:0]         req_org_x;
   logic [9:0]         req_org_y;
   logic [4:0]         req_part_width;
   logic [4:0]         req_part_height;
   logic signed [15:0] req_mvd_x;
   logic signed [15:0] req_mvd_y;
   logic               req_mb_is_intra;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_pred_x;
   logic signed [15:0] rsp_pred_y;
   logic signed [15:0] rsp_final_x;
   logic signed [15:0] rsp_final_y;
   logic               csr_valid;
   logic               csr_ready;
   logic [0:0]         csr_index;
   logic [6:0]         csr_wdata;

   h264_mv_predictor_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_org_x       (req_org_x),
      .req_org_y       (req_org_y),
      .req_part_width  (req_part_width),
      .req_part_height (req_part_height),
      .req_mvd_x       (req_mvd_x),
      .req_mvd_y       (req_mvd_y),
      .req_mb_is_intra (req_mb_is_intra),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pred_x      (rsp_pred_x),
      .rsp_pred_y      (rsp_pred_y),
      .rsp_final_x     (rsp_final_x),
      .rsp_final_y     (rsp_final_y),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Shadow copy of the block's state: one vector per 4x4 block with a
   // present bit, and one intra flag per macroblock. Vectors are only read
   // where the present bit is set, so their initial contents never matter.
   int      vec_x_shadow [BLK_COLS*BLK_COLS];
   int      vec_y_shadow [BLK_COLS*BLK_COLS];
   bit      vec_here     [BLK_COLS*BLK_COLS];
   bit      intra_here   [4096];
   int      pic_w_reg = 64;
   int      pic_h_reg = 64;

   mv_rsp_t pending_mv [$];
   int      mismatches  = 0;
   int      checked     = 0;
   int      sent        = 0;
   int      cycles      = 0;
   int      snd_idle    = 0;
   int      rcv_idle    = 0;
   int      hold_req    = 0;
   int      hold_seen   = 0;
   int      hold_left   = 0;

   // Picture sizes of the random phases.
   int      widths  [6] = '{5, 1, 127, 0, 64, 8};
   int      heights [6] = '{3, 1, 64, 2, 127, 6};

   // Directed requests, run at the reset geometry of 64x64 macroblocks.
   // Rows with typed results are ones whose answer is obvious: clears,
   // marks, derives with no neighbors, and the P_Skip zero cases.
   dir_row_t dir_tab [25] = '{
      '{mvp_pkg::ACT_NEW_PIC, 0, 0, 16, 16, 5, 5, 0, 1, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 0, 0, 16, 16, 32767, -32768, 0, 1, 0, 0, 32767, -32768},
      '{mvp_pkg::ACT_DERIVE, 16, 0, 16, 16, 1, 1, 1, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 32, 0, 16, 16, 32767, -32768, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_MARK, 0, 16, 16, 16, 0, 0, 1, 1, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 16, 16, 16, 8, -7, 9, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 16, 24, 16, 8, 3, -3, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 32, 16, 8, 16, 100, 200, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 40, 16, 8, 16, -100, 50, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 48, 16, 8, 8, 12, -12, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 56, 16, 4, 8, -1, 1, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 60, 16, 4, 4, 4, 4, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_SKIP, 0, 32, 16, 16, 9, 9, 0, 1, 0, 0, 0, 0},
      '{mvp_pkg::ACT_SKIP, 32, 0, 16, 16, 9, 9, 0, 1, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 64, 64, 16, 16, 0, 0, 0, 1, 0, 0, 0, 0},
      '{mvp_pkg::ACT_SKIP, 80, 64, 16, 16, 0, 0, 0, 1, 0, 0, 0, 0},
      '{mvp_pkg::ACT_SKIP, 64, 80, 16, 16, 0, 0, 0, 1, 0, 0, 0, 0},
      '{mvp_pkg::ACT_SKIP, 160, 160, 16, 16, 0, 0, 0, 1, 0, 0, 0, 0},
      '{mvp_pkg::ACT_SKIP, 32, 32, 16, 16, 0, 0, 1, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 100, 100, 0, 0, 5, 5, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 1007, 1009, 31, 5, -32768, 32767, 1, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_MARK, 1023, 1023, 31, 31, -1, -1, 1, 1, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 1020, 1020, 4, 4, -1, -1, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_DERIVE, 1023, 1023, 16, 16, 32767, 32767, 0, 0, 0, 0, 0, 0},
      '{mvp_pkg::ACT_NEW_PIC, 1023, 1023, 31, 31, -1, -1, 1, 1, 0, 0, 0, 0}
   };

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycles, pending_mv.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // The picture size registers are used clamped to the supported range.
   function automatic int mb_cols();
      return (pic_w_reg == 0) ? 1 : ((pic_w_reg > 64) ? 64 : pic_w_reg);
   endfunction

   function automatic int mb_rows();
      return (pic_h_reg == 0) ? 1 : ((pic_h_reg > 64) ? 64 : pic_h_reg);
   endfunction

   // Classify a neighbor pixel: outside the picture or an empty inter
   // block is unavailable, an empty block in an intra macroblock is
   // available but carries no vector, a stored block is valid.
   function automatic nb_t probe(int px, int py);
      nb_t n;
      int  bx, by, i;
      n = '{0, 0, 1'b0, 1'b0};
      if (px < 0 || py < 0) return n;
      bx = px >> 2;
      by = py >> 2;
      if (bx >= mb_cols() * 4 || by >= mb_rows() * 4) return n;
      i = by * BLK_COLS + bx;
      if (vec_here[i]) begin
         n = '{vec_x_shadow[i], vec_y_shadow[i], 1'b1, 1'b1};
      end else if (intra_here[(by >> 2) * 64 + (bx >> 2)]) begin
         n.avail = 1'b1;
      end
      return n;
   endfunction

   function automatic int median3(int a, int b, int c);
      int lo, hi;
      lo = (a < b) ? a : b;
      hi = (a > b) ? a : b;
      if (c < lo) return lo;
      if (c > hi) return hi;
      return c;
   endfunction

   function automatic nb_t neighbor_mv(int ox, int oy, int w, int h);
      nb_t a, b, c, r;
      a = probe(ox - 1, oy);
      b = probe(ox, oy - 1);
      c = probe(ox + w, oy - 1);
      if (!c.avail) c = probe(ox - 1, oy - 1);
      // Directional shortcuts for the two rectangular halves.
      if (w == 16 && h == 8) begin
         if ((oy & 8) != 0) begin
            if (a.valid) return a;
         end else if (b.valid) begin
            return b;
         end
      end
      if (w == 8 && h == 16) begin
         if ((ox & 8) != 0) begin
            if (c.valid) return c;
         end else if (a.valid) begin
            return a;
         end
      end
      if (!b.valid && !c.valid) return a;
      if (!a.valid && b.valid && !c.valid) return b;
      if (!a.valid && !b.valid && c.valid) return c;
      r.x = median3(a.x, b.x, c.x);
      r.y = median3(a.y, b.y, c.y);
      r.avail = 1'b1;
      r.valid = 1'b1;
      return r;
   endfunction

   function automatic int clamp_vec(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function automatic bit zero_stored(int bx, int by);
      int i;
      if (bx < 0 || by < 0 || bx >= mb_cols() * 4 || by >= mb_rows() * 4) return 1'b0;
      i = by * BLK_COLS + bx;
      return vec_here[i] && vec_x_shadow[i] == 0 && vec_y_shadow[i] == 0;
   endfunction

   // Writes are dropped for blocks that fall outside the picture.
   function automatic void store_partition(int ox, int oy, int w, int h, int vx, int vy);
      int i;
      for (int by = oy >> 2; by < (oy >> 2) + (h >> 2); by++) begin
         for (int bx = ox >> 2; bx < (ox >> 2) + (w >> 2); bx++) begin
            if (bx < mb_cols() * 4 && by < mb_rows() * 4) begin
               i = by * BLK_COLS + bx;
               vec_x_shadow[i] = vx;
               vec_y_shadow[i] = vy;
               vec_here[i] = 1'b1;
            end
         end
      end
   endfunction

   // Advance the shadow state by one request and return its result.
   function automatic mv_rsp_t predict_mv(mv_req_t r);
      int  ox, oy, px, py, fx, fy;
      nb_t p;
      bit  zero;
      ox = r.ox;
      oy = r.oy;
      px = 0;
      py = 0;
      fx = 0;
      fy = 0;
      case (r.act)
         mvp_pkg::ACT_NEW_PIC: begin
            foreach (vec_here[i]) vec_here[i] = 1'b0;
            foreach (intra_here[i]) intra_here[i] = 1'b0;
         end
         mvp_pkg::ACT_MARK: begin
            if ((ox >> 4) < mb_cols() && (oy >> 4) < mb_rows())
               intra_here[(oy >> 4) * 64 + (ox >> 4)] = r.intra;
         end
         mvp_pkg::ACT_DERIVE: begin
            p = neighbor_mv(ox, oy, r.w, r.h);
            px = p.x;
            py = p.y;
            fx = clamp_vec(longint'(px) + r.dx);
            fy = clamp_vec(longint'(py) + r.dy);
            store_partition(ox, oy, r.w, r.h, fx, fy);
         end
         default: begin
            zero = ox == 0 || oy == 0 || zero_stored((ox >> 2) - 1, oy >> 2) ||
                   zero_stored(ox >> 2, (oy >> 2) - 1);
            if (!zero) begin
               p = neighbor_mv(ox, oy, 16, 16);
               px = p.x;
               py = p.y;
            end
            fx = px;
            fy = py;
            store_partition(ox, oy, 16, 16, fx, fy);
         end
      endcase
      return '{px[15:0], py[15:0], fx[15:0], fy[15:0]};
   endfunction

   task automatic report_mismatch(string field, logic signed [15:0] got,
                                  logic signed [15:0] want);
      mismatches++;
      $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycles, field, got, want);
   endtask

   // Results are sampled at the rising edge and matched in order.
   always @(posedge clock) begin
      mv_rsp_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked++;
         if (pending_mv.size() == 0) begin
            mismatches++;
            $display("MISMATCH at cycle %0d: result with no request outstanding", cycles);
         end else begin
            want = pending_mv.pop_front();
            if (rsp_pred_x !== want.px) report_mismatch("pred_x", rsp_pred_x, want.px);
            if (rsp_pred_y !== want.py) report_mismatch("pred_y", rsp_pred_y, want.py);
            if (rsp_final_x !== want.fx) report_mismatch("final_x", rsp_final_x, want.fx);
            if (rsp_final_y !== want.fy) report_mismatch("final_y", rsp_final_y, want.fy);
         end
      end
   end

   // The receiver stalls at random, or solidly through a hold-off window once one
   // is asked for. The window is counted here and nowhere else.
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle);
      end
   end

   // Offer one request, idling first at the sender's rate. The expected
   // result is queued on acceptance; a typed result overrides the model's,
   // though the model still runs so that its state stays in step.
   task automatic send_request(mv_req_t r, bit typed = 1'b0, mv_rsp_t typed_rsp = '0);
      mv_rsp_t predicted;
      while ($urandom_range(99) < snd_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action      = r.act;
      req_org_x       = r.ox;
      req_org_y       = r.oy;
      req_part_width  = r.w;
      req_part_height = r.h;
      req_mvd_x       = r.dx;
      req_mvd_y       = r.dy;
      req_mb_is_intra = r.intra;
      req_valid       = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_mv(r);
      pending_mv.push_back(typed ? typed_rsp : predicted);
      sent++;
      @(negedge clock);
   endtask

   // Register writes happen only once every outstanding result is back.
   task automatic write_reg(mvp_pkg::mvp_csr_type idx, logic [6:0] value);
      req_valid = 1'b0;
      while (pending_mv.size() != 0) @(negedge clock);
      csr_index = idx;
      csr_wdata = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == mvp_pkg::CSR_PIC_WIDTH) begin
         pic_w_reg = value;
      end else begin
         pic_h_reg = value;
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [15:0] random_mvd();
      case ($urandom_range(7))
         0: return 16'($urandom());
         1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         2: return '0;
         default: return 16'($signed($urandom_range(128)) - 64);
      endcase
   endfunction

   task automatic emit_part(mvp_pkg::mvp_action_type act, int ox, int oy, int w, int h);
      mv_req_t r;
      r = '{act, ox[9:0], oy[9:0], w[4:0], h[4:0], random_mvd(), random_mvd(),
            1'($urandom_range(1))};
      send_request(r);
   endtask

   // Raster walks over the current picture with legal partitionings, mixed
   // with intra marks and some fully random requests. New pictures are
   // avoided here since each one costs a long clearing sweep.
   task automatic run_phase(int quota, bit pressure, bit drain_midway);
      int       first, r, ox, oy;
      bit       held, drained;
      mv_req_t  noise;
      first   = sent;
      held    = 1'b0;
      drained = 1'b0;
      while (sent - first < quota) begin
         for (int my = 0; my < mb_rows() && sent - first < quota; my++) begin
            for (int mx = 0; mx < mb_cols() && sent - first < quota; mx++) begin
               ox = mx * 16;
               oy = my * 16;
               r = $urandom_range(99);
               if (pressure && !held && sent - first >= 2) begin
                  // Hold the result side off while requests keep coming.
                  held = 1'b1;
                  hold_req++;
               end
               if (drain_midway && !drained && sent - first >= 40) begin
                  drained   = 1'b1;
                  req_valid = 1'b0;
                  while (pending_mv.size() != 0) @(negedge clock);
               end
               if (r < 8) begin
                  emit_part(mvp_pkg::ACT_MARK, ox, oy, 16, 16);
               end else if (r < 28) begin
                  emit_part(mvp_pkg::ACT_SKIP, ox, oy, 16, 16);
               end else if (r < 45) begin
                  emit_part(mvp_pkg::ACT_DERIVE, ox, oy, 16, 16);
               end else if (r < 57) begin
                  emit_part(mvp_pkg::ACT_DERIVE, ox, oy, 16, 8);
                  emit_part(mvp_pkg::ACT_DERIVE, ox, oy + 8, 16, 8);
               end else if (r < 69) begin
                  emit_part(mvp_pkg::ACT_DERIVE, ox, oy, 8, 16);
                  emit_part(mvp_pkg::ACT_DERIVE, ox + 8, oy, 8, 16);
               end else if (r < 87) begin
                  for (int s = 0; s < 4; s++) begin
                     int sx, sy;
                     sx = ox + (s & 1) * 8;
                     sy = oy + (s >> 1) * 8;
                     case ($urandom_range(3))
                        0: emit_part(mvp_pkg::ACT_DERIVE, sx, sy, 8, 8);
                        1: begin
                           emit_part(mvp_pkg::ACT_DERIVE, sx, sy, 8, 4);
                           emit_part(mvp_pkg::ACT_DERIVE, sx, sy + 4, 8, 4);
                        end
                        2: begin
                           emit_part(mvp_pkg::ACT_DERIVE, sx, sy, 4, 8);
                           emit_part(mvp_pkg::ACT_DERIVE, sx + 4, sy, 4, 8);
                        end
                        default: begin
                           for (int q = 0; q < 4; q++)
                              emit_part(mvp_pkg::ACT_DERIVE, sx + (q & 1) * 4,
                                        sy + (q >> 1) * 4, 4, 4);
                        end
                     endcase
                  end
               end else begin
                  noise.act   = mvp_pkg::mvp_action_type'($urandom_range(3, 1));
                  noise.ox    = 10'($urandom());
                  noise.oy    = 10'($urandom());
                  noise.w     = 5'($urandom());
                  noise.h     = 5'($urandom());
                  noise.dx    = 16'($urandom());
                  noise.dy    = 16'($urandom());
                  noise.intra = 1'($urandom());
                  send_request(noise);
               end
            end
         end
      end
   endtask

   initial begin
      mv_req_t r;
      mv_rsp_t t;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = mvp_pkg::ACT_NEW_PIC;
      req_org_x       = '0;
      req_org_y       = '0;
      req_part_width  = '0;
      req_part_height = '0;
      req_mvd_x       = '0;
      req_mvd_y       = '0;
      req_mb_is_intra = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = mvp_pkg::CSR_PIC_WIDTH;
      csr_wdata       = '0;
      foreach (vec_here[i]) vec_here[i] = 1'b0;
      foreach (intra_here[i]) intra_here[i] = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed requests at the reset geometry, with steady handshakes.
      foreach (dir_tab[i]) begin
         r = '{dir_tab[i].act, dir_tab[i].ox[9:0], dir_tab[i].oy[9:0],
               dir_tab[i].w[4:0], dir_tab[i].h[4:0], dir_tab[i].dx[15:0],
               dir_tab[i].dy[15:0], dir_tab[i].intra};
         t = '{dir_tab[i].epx[15:0], dir_tab[i].epy[15:0],
               dir_tab[i].efx[15:0], dir_tab[i].efy[15:0]};
         send_request(r, dir_tab[i].typed, t);
      end

      // Random phases, each at its own picture size and starting from a
      // cleared picture. The first pair idles the sender lightly and the
      // receiver heavily, the next pair the reverse, the last pair neither.
      for (int ph = 0; ph < 6; ph++) begin
         snd_idle = (ph < 2) ? 11 : ((ph < 4) ? 73 : 0);
         rcv_idle = (ph < 2) ? 73 : ((ph < 4) ? 11 : 0);
         write_reg(mvp_pkg::CSR_PIC_WIDTH, 7'(widths[ph]));
         write_reg(mvp_pkg::CSR_PIC_HEIGHT, 7'(heights[ph]));
         r = '{mvp_pkg::ACT_NEW_PIC, 10'($urandom()), 10'($urandom()), 5'($urandom()),
               5'($urandom()), 16'($urandom()), 16'($urandom()), 1'($urandom())};
         send_request(r, 1'b1, '0);
         run_phase(80, ph == 4, ph == 2);
      end
      req_valid = 1'b0;

      while (pending_mv.size() != 0) @(negedge clock);
      repeat (64) @(negedge clock);

      $display("Sent %0d requests (directed, six picture sizes, clears, marks,",
               sent);
      $display("derives and skips); checked %0d results.", checked);
      if (mismatches == 0 && pending_mv.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/mvp_pkg.sv
hdl/mvp_front.sv
hdl/mvp_queue.sv
hdl/mvp_back.sv
hdl/h264_mv_predictor_core.sv
dv/h264_mv_predictor_core_tb.sv
